// ===== src/drc_pkg.sv =====
// Shared types, constants and register codes for the stereo compressor.
package drc_pkg;

  localparam int NUM_IN       = 2;
  localparam int CH_W         = 1;
  localparam int CHANNELS_DEF = 2;

  localparam int SAMPLE_W = 24;
  localparam int ENV_W    = 24;
  localparam int GAIN_W   = 16;
  localparam int TGT_W    = 17;
  localparam int COEF_W   = 16;
  localparam int THR_W    = 23;
  localparam int RATIO_W  = 5;

  localparam int IN_DATA_W  = NUM_IN * SAMPLE_W;
  localparam int OUT_DATA_W = NUM_IN * SAMPLE_W;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 23;

  localparam logic [THR_W-1:0]   THRESHOLD_RST    = THR_W'(3000000);
  localparam logic [RATIO_W-1:0] RATIO_RST        = RATIO_W'(2);
  localparam logic [COEF_W-1:0]  ENV_ATTACK_RST   = COEF_W'(4096);
  localparam logic [COEF_W-1:0]  ENV_RELEASE_RST  = COEF_W'(256);
  localparam logic [COEF_W-1:0]  GAIN_ATTACK_RST  = COEF_W'(8192);
  localparam logic [COEF_W-1:0]  GAIN_RELEASE_RST = COEF_W'(512);

  localparam logic [GAIN_W-1:0]   GAIN_UNITY = GAIN_W'(32768);
  localparam logic [TGT_W-1:0]    TGT_UNITY  = TGT_W'(32768);
  localparam logic [ENV_W-1:0]    ENV_MAX    = {ENV_W{1'b1}};
  localparam logic [SAMPLE_W-1:0] S24_MAX    = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam logic [SAMPLE_W-1:0] S24_MIN    = {1'b1, {(SAMPLE_W-1){1'b0}}};

  // Shared multiplier geometry and Q15 scaling.
  localparam int MUL_A_W = 26;
  localparam int MUL_B_W = 18;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;
  localparam int Q_SHIFT = 15;
  localparam int SH_W    = MUL_P_W - Q_SHIFT;
  localparam int SUM_W   = SH_W + 1;

  // Serial divider geometry.
  localparam int DIV_W      = 24;
  localparam int DIV_CNT_W  = 5;
  localparam logic [DIV_CNT_W-1:0] DIV1_STEPS = DIV_CNT_W'(24);
  localparam logic [DIV_CNT_W-1:0] DIV2_STEPS = DIV_CNT_W'(15);

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_THRESHOLD    = 3'd0,
    REG_RATIO        = 3'd1,
    REG_ENV_ATTACK   = 3'd2,
    REG_ENV_RELEASE  = 3'd3,
    REG_GAIN_ATTACK  = 3'd4,
    REG_GAIN_RELEASE = 3'd5
  } cfg_reg_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CH,
    S_ENV_UPD,
    S_THR,
    S_DIV1,
    S_OENV_CHK,
    S_DIV2,
    S_GAIN_MUL,
    S_GAIN_UPD,
    S_OUT_MUL,
    S_OUT_UPD,
    S_NEXT,
    S_DONE
  } drc_state_t;

  typedef enum logic [1:0] {
    MUL_ENV,
    MUL_GAIN,
    MUL_OUT
  } mul_sel_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_CNT_W-1:0] steps;
    logic [DIV_W-1:0]     rem0;
    logic [DIV_W-1:0]     num;
    logic [DIV_W-1:0]     den;
  } drc_div_req_t;

endpackage

// ===== src/drc_mul.sv =====
// Shared signed multiplier with a registered product.
module drc_mul (
  input  logic                                clk,
  input  logic signed [drc_pkg::MUL_A_W-1:0]  a,
  input  logic signed [drc_pkg::MUL_B_W-1:0]  b,
  output logic signed [drc_pkg::MUL_P_W-1:0]  prod
);
  import drc_pkg::*;

  logic signed [MUL_P_W-1:0] prod_r;

  always_ff @(posedge clk) begin
    prod_r <= a * b;
  end

  assign prod = prod_r;

endmodule

// ===== src/drc_div.sv =====
// Restoring serial divider, one quotient bit per cycle.
module drc_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  drc_pkg::drc_div_req_t      req,
  output logic                       done,
  output logic [drc_pkg::DIV_W-1:0]  quot
);
  import drc_pkg::*;

  logic                 busy_r;
  logic                 done_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [DIV_W-1:0]     rem_r;
  logic [DIV_W-1:0]     num_r;
  logic [DIV_W-1:0]     den_r;
  logic [DIV_W-1:0]     quot_r;

  logic [DIV_W:0] trial;
  logic [DIV_W:0] trial_sub;
  logic           fits;

  assign trial     = {rem_r, num_r[DIV_W-1]};
  assign trial_sub = trial - {1'b0, den_r};
  assign fits      = (trial >= {1'b0, den_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= req.steps;
      end else if (busy_r) begin
        cnt_r <= cnt_r - DIV_CNT_W'(1);
        if (cnt_r == DIV_CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Shift the next dividend bit in, subtract where the divisor fits.
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r  <= req.rem0;
      num_r  <= req.num;
      den_r  <= req.den;
      quot_r <= '0;
    end else if (busy_r) begin
      rem_r  <= fits ? trial_sub[DIV_W-1:0] : trial[DIV_W-1:0];
      num_r  <= {num_r[DIV_W-2:0], 1'b0};
      quot_r <= {quot_r[DIV_W-2:0], fits};
    end
  end

  assign done = done_r;
  assign quot = quot_r;

endmodule

// ===== src/stereo_dynamic_range_compressor.sv =====
// A stereo pair is processed one channel after the other; a channel over threshold waits in
// the serial divider for the ratio division (24 steps) and, unless its output level equals
// its envelope, for the Q15 gain division (15 steps).
// A new pair is taken only after the last one is finished: in_tready is high only while idle.
// Reset (rst_n low, synchronous): registers take their reset values, envelopes go to
// zero, gains to unity, and any transaction in flight is dropped.
module stereo_dynamic_range_compressor #(
  parameter int CHANNELS = drc_pkg::CHANNELS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // Input stream; tdata: left_sample [23:0], right_sample [47:24]
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [drc_pkg::IN_DATA_W-1:0]      in_tdata,
  // Result stream; tdata: left_out [23:0], right_out [47:24]
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [drc_pkg::OUT_DATA_W-1:0]     out_tdata,
  // Configuration write port
  input  logic                               cfg_we,
  input  logic [drc_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [drc_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import drc_pkg::*;

  // Channels that carry envelope and gain state; the rest pass through.
  localparam int ACT   = (CHANNELS < NUM_IN) ? CHANNELS : NUM_IN;
  localparam int ACT_W = (ACT > 1) ? $clog2(ACT) : 1;

  // Configuration registers
  logic [THR_W-1:0]   thr_r;
  logic [RATIO_W-1:0] ratio_r;
  logic [COEF_W-1:0]  env_attack_r;
  logic [COEF_W-1:0]  env_release_r;
  logic [COEF_W-1:0]  gain_attack_r;
  logic [COEF_W-1:0]  gain_release_r;

  // Sequencer and channel state
  drc_state_t         state_r, state_nxt;
  logic [CH_W-1:0]    ch_r;
  logic [ENV_W-1:0]   env_r  [ACT];
  logic [GAIN_W-1:0]  gain_r [ACT];

  // Per-item payload
  logic [SAMPLE_W-1:0]   x_r [NUM_IN];
  logic [SAMPLE_W-1:0]   y_r [NUM_IN];
  logic [TGT_W-1:0]      target_r;
  logic [ENV_W-1:0]      oenv_r;
  logic                  out_tvalid_r;
  logic [OUT_DATA_W-1:0] out_tdata_r;

  // Control decoded from the state
  mul_sel_t     mul_sel;
  drc_div_req_t div_req;
  logic         out_free;

  // Shared units
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [MUL_P_W-1:0] mul_p;
  logic                      div_done;
  logic [DIV_W-1:0]          div_quot;

  // Datapath around the shared units
  logic                  ch_active;
  logic [ACT_W-1:0]      idx;
  logic [SAMPLE_W-1:0]   x_cur;
  logic [ENV_W-1:0]      env_cur;
  logic [GAIN_W-1:0]     gain_cur;
  logic [SAMPLE_W:0]     xs;
  logic [SAMPLE_W:0]     mag;
  logic [MUL_A_W-1:0]    env_diff;
  logic                  diff_pos;
  logic [TGT_W:0]        gain_diff;
  logic                  gd_neg;
  logic                  env_gt_thr;
  logic [RATIO_W-1:0]    ratio_eff;
  logic [ENV_W-1:0]      oenv_sum;
  logic [SH_W-1:0]       prod_sh;
  logic [SUM_W-1:0]      env_sum;
  logic [SUM_W-1:0]      gain_sum;
  logic [ENV_W-1:0]      env_new;
  logic [GAIN_W-1:0]     gain_new;
  logic [SAMPLE_W-1:0]   y_new;
  logic [OUT_DATA_W-1:0] y_pack;

  assign ch_active = (int'(ch_r) < ACT);
  assign idx       = ch_active ? ACT_W'(ch_r) : '0;
  assign x_cur     = x_r[ch_r];
  assign env_cur   = env_r[idx];
  assign gain_cur  = gain_r[idx];
  assign out_free  = !out_tvalid_r || out_tready;

  // Envelope step: |x| - env, attack coefficient only while the level rises.
  assign xs       = {x_cur[SAMPLE_W-1], x_cur};
  assign mag      = x_cur[SAMPLE_W-1] ? (~xs + (SAMPLE_W+1)'(1)) : xs;
  assign env_diff = {1'b0, mag} - {{(MUL_A_W-ENV_W){1'b0}}, env_cur};
  assign diff_pos = !env_diff[MUL_A_W-1] && (env_diff != '0);

  // Gain step: target - gain, attack coefficient while the gain falls.
  assign gain_diff = {1'b0, target_r} - {{(TGT_W+1-GAIN_W){1'b0}}, gain_cur};
  assign gd_neg    = gain_diff[TGT_W];

  assign env_gt_thr = (env_cur > {1'b0, thr_r});
  assign ratio_eff  = (ratio_r == '0) ? RATIO_W'(1) : ratio_r;
  assign oenv_sum   = {1'b0, thr_r} + div_quot[ENV_W-1:0];

  // Product >>> 15, then the per-step clamps.
  assign prod_sh  = mul_p[MUL_P_W-1:Q_SHIFT];
  assign env_sum  = {prod_sh[SH_W-1], prod_sh} + {{(SUM_W-ENV_W){1'b0}}, env_cur};
  assign gain_sum = {prod_sh[SH_W-1], prod_sh} + {{(SUM_W-GAIN_W){1'b0}}, gain_cur};

  always_comb begin
    if (env_sum[SUM_W-1]) begin
      env_new = '0;
    end else if (env_sum[SUM_W-2:ENV_W] != '0) begin
      env_new = ENV_MAX;
    end else begin
      env_new = env_sum[ENV_W-1:0];
    end
  end

  always_comb begin
    if (gain_sum[SUM_W-1]) begin
      gain_new = '0;
    end else if (gain_sum > {{(SUM_W-TGT_W){1'b0}}, TGT_UNITY}) begin
      gain_new = GAIN_UNITY;
    end else begin
      gain_new = gain_sum[GAIN_W-1:0];
    end
  end

  // Saturate the scaled sample to signed 24 bits.
  always_comb begin
    if ((prod_sh[SH_W-1:SAMPLE_W-1] == '0) || (prod_sh[SH_W-1:SAMPLE_W-1] == '1)) begin
      y_new = prod_sh[SAMPLE_W-1:0];
    end else if (prod_sh[SH_W-1]) begin
      y_new = S24_MIN;
    end else begin
      y_new = S24_MAX;
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_IN; i++) begin
      y_pack[i*SAMPLE_W +: SAMPLE_W] = y_r[i];
    end
  end

  // Operand select for the shared multiplier.
  always_comb begin
    case (mul_sel)
      MUL_GAIN: begin
        mul_a = $signed({{(MUL_A_W-TGT_W-1){gain_diff[TGT_W]}}, gain_diff});
        mul_b = $signed({{(MUL_B_W-COEF_W){1'b0}}, gd_neg ? gain_attack_r : gain_release_r});
      end
      MUL_OUT: begin
        mul_a = $signed({{(MUL_A_W-SAMPLE_W){x_cur[SAMPLE_W-1]}}, x_cur});
        mul_b = $signed({{(MUL_B_W-GAIN_W){1'b0}}, gain_cur});
      end
      default: begin
        mul_a = $signed(env_diff);
        mul_b = $signed({{(MUL_B_W-COEF_W){1'b0}}, diff_pos ? env_attack_r : env_release_r});
      end
    endcase
  end

  drc_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (mul_p)
  );

  drc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .done  (div_done),
    .quot  (div_quot)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:     if (in_tvalid) state_nxt = S_CH;
      S_CH:       state_nxt = ch_active ? S_ENV_UPD : S_NEXT;
      S_ENV_UPD:  state_nxt = S_THR;
      S_THR:      state_nxt = env_gt_thr ? S_DIV1 : S_GAIN_MUL;
      S_DIV1:     if (div_done) state_nxt = S_OENV_CHK;
      S_OENV_CHK: state_nxt = (oenv_r == env_cur) ? S_GAIN_MUL : S_DIV2;
      S_DIV2:     if (div_done) state_nxt = S_GAIN_MUL;
      S_GAIN_MUL: state_nxt = S_GAIN_UPD;
      S_GAIN_UPD: state_nxt = S_OUT_MUL;
      S_OUT_MUL:  state_nxt = S_OUT_UPD;
      S_OUT_UPD:  state_nxt = S_NEXT;
      S_NEXT:     state_nxt = (ch_r == CH_W'(NUM_IN-1)) ? S_DONE : S_CH;
      S_DONE:     if (out_free) state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  // Outputs of the sequencer: handshake, multiplier select, divider launch.
  always_comb begin
    in_tready     = 1'b0;
    mul_sel       = MUL_ENV;
    div_req.start = 1'b0;
    div_req.steps = DIV1_STEPS;
    div_req.rem0  = '0;
    div_req.num   = env_cur - {1'b0, thr_r};
    div_req.den   = {{(DIV_W-RATIO_W){1'b0}}, ratio_eff};
    case (state_r)
      S_IDLE:     in_tready = 1'b1;
      S_CH:       mul_sel = MUL_ENV;
      S_THR:      div_req.start = env_gt_thr;
      S_OENV_CHK: begin
        // out_env < env here, so the quotient fits 15 bits
        div_req.start = (oenv_r != env_cur);
        div_req.steps = DIV2_STEPS;
        div_req.rem0  = oenv_r;
        div_req.num   = '0;
        div_req.den   = env_cur;
      end
      S_GAIN_MUL: mul_sel = MUL_GAIN;
      S_OUT_MUL:  mul_sel = MUL_OUT;
      default:    in_tready = 1'b0;
    endcase
  end

  // Control, configuration and channel state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      ch_r           <= '0;
      out_tvalid_r   <= 1'b0;
      thr_r          <= THRESHOLD_RST;
      ratio_r        <= RATIO_RST;
      env_attack_r   <= ENV_ATTACK_RST;
      env_release_r  <= ENV_RELEASE_RST;
      gain_attack_r  <= GAIN_ATTACK_RST;
      gain_release_r <= GAIN_RELEASE_RST;
      for (int i = 0; i < ACT; i++) begin
        env_r[i]  <= '0;
        gain_r[i] <= GAIN_UNITY;
      end
    end else begin
      state_r <= state_nxt;

      if (cfg_we) begin
        case (cfg_reg_t'(cfg_addr))
          REG_THRESHOLD:    thr_r          <= cfg_wdata[THR_W-1:0];
          REG_RATIO:        ratio_r        <= cfg_wdata[RATIO_W-1:0];
          REG_ENV_ATTACK:   env_attack_r   <= cfg_wdata[COEF_W-1:0];
          REG_ENV_RELEASE:  env_release_r  <= cfg_wdata[COEF_W-1:0];
          REG_GAIN_ATTACK:  gain_attack_r  <= cfg_wdata[COEF_W-1:0];
          REG_GAIN_RELEASE: gain_release_r <= cfg_wdata[COEF_W-1:0];
          default: ;
        endcase
      end

      if (state_r == S_IDLE && in_tvalid) begin
        ch_r <= '0;
      end else if (state_r == S_NEXT && ch_r != CH_W'(NUM_IN-1)) begin
        ch_r <= ch_r + CH_W'(1);
      end

      if (state_r == S_ENV_UPD) begin
        env_r[idx] <= env_new;
      end
      if (state_r == S_GAIN_UPD) begin
        gain_r[idx] <= gain_new;
      end

      // A waiting result drops once taken; a finished item refills the slot.
      if (state_r == S_DONE && out_free) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  // Payload: samples, intermediate levels, results
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_tvalid) begin
      for (int i = 0; i < NUM_IN; i++) begin
        x_r[i] <= in_tdata[i*SAMPLE_W +: SAMPLE_W];
      end
    end

    case (state_r)
      S_CH:       if (!ch_active) y_r[ch_r] <= x_cur;
      S_THR:      if (!env_gt_thr) target_r <= TGT_UNITY;
      S_DIV1:     if (div_done) oenv_r <= oenv_sum;
      S_OENV_CHK: if (oenv_r == env_cur) target_r <= TGT_UNITY;
      S_DIV2:     if (div_done) target_r <= {{(TGT_W-15){1'b0}}, div_quot[14:0]};
      S_OUT_UPD:  y_r[ch_r] <= y_new;
      default: ;
    endcase

    if (state_r == S_DONE && out_free) begin
      out_tdata_r <= y_pack;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the stereo dynamic range compressor.
module tb_top;
  import drc_pkg::*;

  // Run control
  localparam int CYCLE_LIMIT     = 1_000_000;
  localparam int SETTLE_CYCLES   = 120;   // a little over the worst-case latency
  localparam int HOLD_OFF_CYCLES = 1500;
  localparam int RAND_PHASES     = 8;
  localparam int PHASE_PAIRS     = 72;
  localparam int BURST_PAIRS     = 24;
  localparam int MAX_PRINTS      = 100;

  // Fixed-point limits used by the gain computer mirror
  localparam longint Q15_ONE   = 32768;
  localparam longint SAMPLE_HI = 8388607;
  localparam longint SAMPLE_LO = -8388608;

  // Register indexes past the end of the map; writes to them must be ignored
  localparam logic [CFG_ADDR_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_ADDR_W-1:0] REG_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [SAMPLE_W-1:0] right;
    logic [SAMPLE_W-1:0] left;
  } stereo_pair_t;

  typedef enum logic {
    ROW_PAIR,
    ROW_WRITE
  } row_op_t;

  // One step of the directed sequence: either a register write or a stereo pair.
  // A pair row with golden set carries its expected output typed in.
  typedef struct packed {
    row_op_t               op;
    logic [CFG_ADDR_W-1:0] addr;
    logic [CFG_DATA_W-1:0] wdata;
    logic [SAMPLE_W-1:0]   left;
    logic [SAMPLE_W-1:0]   right;
    logic                  golden;
    logic [SAMPLE_W-1:0]   gold_left;
    logic [SAMPLE_W-1:0]   gold_right;
  } stim_row_t;

  localparam int NUM_ROWS = 38;

  stim_row_t directed_rows [NUM_ROWS] = '{
    // Reset settings: envelope starts at zero, so the first pairs pass at unity gain
    '{ROW_PAIR,  '0, '0, '0, '0, 1'b1, '0, '0},
    '{ROW_PAIR,  '0, '0, S24_MAX, S24_MIN, 1'b1, S24_MAX, S24_MIN},
    '{ROW_PAIR,  '0, '0, S24_MIN, S24_MAX, 1'b0, '0, '0},
    '{ROW_PAIR,  '0, '0, S24_MAX, S24_MAX, 1'b0, '0, '0},
    '{ROW_PAIR,  '0, '0, 24'hFFFFFF, 24'h000001, 1'b0, '0, '0},
    // Zero threshold, steepest in-range ratio: everything is over threshold
    '{ROW_WRITE, REG_THRESHOLD, 23'd0, '0, '0, 1'b0, '0, '0},
    '{ROW_WRITE, REG_RATIO, 23'd16, '0, '0, 1'b0, '0, '0},
    '{ROW_PAIR,  '0, '0, S24_MAX, S24_MIN, 1'b0, '0, '0},
    '{ROW_PAIR,  '0, '0, 24'h400000, 24'hC00000, 1'b0, '0, '0},
    // Ratio of zero behaves as one
    '{ROW_WRITE, REG_RATIO, 23'd0, '0, '0, 1'b0, '0, '0},
    '{ROW_PAIR,  '0, '0, S24_MAX, S24_MIN, 1'b0, '0, '0},
    // Coefficients above unity: envelope overshoots both ways, gain is clamped
    '{ROW_WRITE, REG_ENV_ATTACK, 23'h00FFFF, '0, '0, 1'b0, '0, '0},
    '{ROW_WRITE, REG_ENV_RELEASE, 23'h00FFFF, '0, '0, 1'b0, '0, '0},
    '{ROW_WRITE, REG_GAIN_ATTACK, 23'h00FFFF, '0, '0, 1'b0, '0, '0},
    '{ROW_WRITE, REG_GAIN_RELEASE, 23'h00FFFF, '0, '0, 1'b0, '0, '0},
    '{ROW_PAIR,  '0, '0, S24_MIN, S24_MAX, 1'b0, '0, '0},
    '{ROW_PAIR,  '0, '0, '0, '0, 1'b0, '0, '0},
    '{ROW_PAIR,  '0, '0, S24_MAX, S24_MIN, 1'b0, '0, '0},
    // Writes past the register map change nothing
    '{ROW_WRITE, REG_SPARE_LO, 23'h7FFFFF, '0, '0, 1'b0, '0, '0},
    '{ROW_WRITE, REG_SPARE_HI, 23'h000001, '0, '0, 1'b0, '0, '0},
    '{ROW_PAIR,  '0, '0, 24'h2AAAAA, 24'hD55555, 1'b0, '0, '0},
    // Top threshold, largest ratio code, frozen envelope and gain
    '{ROW_WRITE, REG_THRESHOLD, 23'h7FFFFF, '0, '0, 1'b0, '0, '0},
    '{ROW_WRITE, REG_RATIO, 23'd31, '0, '0, 1'b0, '0, '0},
    '{ROW_WRITE, REG_ENV_ATTACK, 23'd0, '0, '0, 1'b0, '0, '0},
    '{ROW_WRITE, REG_ENV_RELEASE, 23'd0, '0, '0, 1'b0, '0, '0},
    '{ROW_WRITE, REG_GAIN_ATTACK, 23'd0, '0, '0, 1'b0, '0, '0},
    '{ROW_WRITE, REG_GAIN_RELEASE, 23'd0, '0, '0, 1'b0, '0, '0},
    '{ROW_PAIR,  '0, '0, S24_MAX, S24_MIN, 1'b0, '0, '0},
    '{ROW_PAIR,  '0, '0, 24'h5A5A5A, 24'hA5A5A5, 1'b0, '0, '0},
    // Unity coefficients: envelope and gain jump straight to their targets
    '{ROW_WRITE, REG_THRESHOLD, 23'd1, '0, '0, 1'b0, '0, '0},
    '{ROW_WRITE, REG_ENV_ATTACK, 23'd32768, '0, '0, 1'b0, '0, '0},
    '{ROW_WRITE, REG_ENV_RELEASE, 23'd32768, '0, '0, 1'b0, '0, '0},
    '{ROW_WRITE, REG_GAIN_ATTACK, 23'd32768, '0, '0, 1'b0, '0, '0},
    '{ROW_WRITE, REG_GAIN_RELEASE, 23'd32768, '0, '0, 1'b0, '0, '0},
    '{ROW_WRITE, REG_RATIO, 23'd1, '0, '0, 1'b0, '0, '0},
    '{ROW_PAIR,  '0, '0, S24_MAX, S24_MIN, 1'b0, '0, '0},
    '{ROW_PAIR,  '0, '0, 24'h000001, 24'hFFFFFF, 1'b0, '0, '0},
    '{ROW_PAIR,  '0, '0, 24'h5A5A5A, 24'hA5A5A5, 1'b0, '0, '0}
  };

  // DUT ports, all known from time zero
  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_we     = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr   = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata  = '0;

  // Bench bookkeeping
  int           cycles       = 0;
  int           mismatches   = 0;
  int           gap_pct      = 0;   // chance of a sender gap before each pair
  int           stall_pct    = 0;   // chance of a receiver stall after each ready cycle
  bit           hold_off_req = 1'b0;
  stereo_pair_t pending_pairs [$];

  // Mirror of the block's registers and per-channel state
  logic [THR_W-1:0]   thr_q;
  logic [RATIO_W-1:0] ratio_q;
  logic [COEF_W-1:0]  env_att_q;
  logic [COEF_W-1:0]  env_rel_q;
  logic [COEF_W-1:0]  gain_att_q;
  logic [COEF_W-1:0]  gain_rel_q;
  longint             env_q  [NUM_IN];
  longint             gain_q [NUM_IN];

  stereo_dynamic_range_compressor dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Hard stop in case the handshake hangs
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("** stereo_dynamic_range_compressor: FAILED **");
      $finish;
    end
  end

  function automatic longint clip(longint v, longint lo, longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // Advance one channel's envelope and gain by one sample and return the
  // compressed sample. Every shift is arithmetic, every division truncates.
  function automatic logic [SAMPLE_W-1:0] compress_sample(int ch,
                                                          logic signed [SAMPLE_W-1:0] x);
    longint xs, mag, env, dif, k, thr, dv, oenv, tgt, g, gd, kg, y;
    xs  = longint'(x);
    mag = (xs < 0) ? -xs : xs;

    // Peak envelope: attack while the level rises, release otherwise
    env = env_q[ch];
    dif = mag - env;
    k   = (dif > 0) ? longint'(env_att_q) : longint'(env_rel_q);
    env = clip(env + ((k * dif) >>> 15), 0, longint'(ENV_MAX));
    env_q[ch] = env;

    // Static curve: unity below threshold, (thr + over/ratio)/env above it
    tgt = Q15_ONE;
    thr = longint'(thr_q);
    if (env > thr) begin
      dv   = (ratio_q == '0) ? 1 : longint'(ratio_q);
      oenv = thr + (env - thr) / dv;
      tgt  = clip((oenv * Q15_ONE) / env, 0, Q15_ONE);
    end

    // Gain smoothing: fast when the gain drops, slow when it recovers
    g  = gain_q[ch];
    gd = tgt - g;
    kg = (gd < 0) ? longint'(gain_att_q) : longint'(gain_rel_q);
    g  = clip(g + ((kg * gd) >>> 15), 0, Q15_ONE);
    gain_q[ch] = g;

    y = clip((xs * g) >>> 15, SAMPLE_LO, SAMPLE_HI);
    return y[SAMPLE_W-1:0];
  endfunction

  // Random idle length: mostly none, often short, occasionally long
  function automatic int idle_len(int pct);
    if ($urandom_range(0, 99) >= pct) return 0;
    if ($urandom_range(0, 9) == 0) return $urandom_range(20, 120);
    return $urandom_range(1, 4);
  endfunction

  // Sample around the current burst level, with full-scale and raw random mixed in
  function automatic logic [SAMPLE_W-1:0] random_sample(int amp);
    case ($urandom_range(0, 19))
      0:       return S24_MAX;
      1:       return S24_MIN;
      2:       return '0;
      3, 4:    return SAMPLE_W'($urandom);
      default: return SAMPLE_W'(int'($urandom_range(0, 2 * amp)) - amp);
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatches < MAX_PRINTS) $display("[cycle %0d] mismatch: %s", cycles, msg);
    mismatches++;
  endtask

  // Called at a falling edge with the block idle; update the register mirror too
  task automatic cfg_write(input logic [CFG_ADDR_W-1:0] addr,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we    = 1'b1;
    cfg_addr  = addr;
    cfg_wdata = data;
    case (addr)
      REG_THRESHOLD:    thr_q      = data[THR_W-1:0];
      REG_RATIO:        ratio_q    = data[RATIO_W-1:0];
      REG_ENV_ATTACK:   env_att_q  = data[COEF_W-1:0];
      REG_ENV_RELEASE:  env_rel_q  = data[COEF_W-1:0];
      REG_GAIN_ATTACK:  gain_att_q = data[COEF_W-1:0];
      REG_GAIN_RELEASE: gain_rel_q = data[COEF_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Offer one stereo pair, starting and ending at a falling edge. Valid stays
  // high across back-to-back pairs; it only drops for a gap.
  task automatic send_pair(input logic [SAMPLE_W-1:0] left_in, right_in,
                           input logic golden,
                           input logic [SAMPLE_W-1:0] gold_left, gold_right);
    int           gap;
    stereo_pair_t want;
    gap = idle_len(gap_pct);
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tdata  = {right_in, left_in};
    in_tvalid = 1'b1;
    do @(posedge clk); while (!in_tready);
    want.left  = compress_sample(0, left_in);
    want.right = compress_sample(1, right_in);
    if (golden) begin
      want.left  = gold_left;
      want.right = gold_right;
    end
    pending_pairs.push_back(want);
    @(negedge clk);
  endtask

  // Stop offering and wait until every accepted pair has come back
  task automatic drain_results();
    in_tvalid = 1'b0;
    while (pending_pairs.size() != 0) @(negedge clk);
  endtask

  // Receiver: random stalls, plus one long hold-off on request so the block
  // backs up and holds in_tready low while the sender keeps offering.
  initial begin : result_sink
    int stall;
    stall = 0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        out_tready = 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
        hold_off_req = 1'b0;
      end
      if (stall > 0) begin
        out_tready = 1'b0;
        stall--;
      end else begin
        out_tready = 1'b1;
        stall = idle_len(stall_pct);
      end
    end
  end

  // Compare each result transaction with the oldest expected pair
  always @(posedge clk) begin : result_check
    stereo_pair_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_pairs.size() == 0) begin
        report_mismatch($sformatf("result %h with nothing pending", out_tdata));
      end else begin
        want = pending_pairs.pop_front();
        if (out_tdata[SAMPLE_W-1:0] !== want.left)
          report_mismatch($sformatf("left_out expected %0d got %0d",
                                    $signed(want.left), $signed(out_tdata[SAMPLE_W-1:0])));
        if (out_tdata[2*SAMPLE_W-1:SAMPLE_W] !== want.right)
          report_mismatch($sformatf("right_out expected %0d got %0d",
                                    $signed(want.right),
                                    $signed(out_tdata[2*SAMPLE_W-1:SAMPLE_W])));
      end
    end
  end

  initial begin : stimulus
    int                    amp;
    logic [CFG_DATA_W-1:0] val;

    // Mirror starts from the reset values
    thr_q      = THRESHOLD_RST;
    ratio_q    = RATIO_RST;
    env_att_q  = ENV_ATTACK_RST;
    env_rel_q  = ENV_RELEASE_RST;
    gain_att_q = GAIN_ATTACK_RST;
    gain_rel_q = GAIN_RELEASE_RST;
    foreach (env_q[c]) begin
      env_q[c]  = 0;
      gain_q[c] = Q15_ONE;
    end
    amp = 0;

    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    // Directed sequence: walk the table, draining before each register write
    gap_pct   = 30;
    stall_pct = 30;
    foreach (directed_rows[i]) begin
      if (directed_rows[i].op == ROW_WRITE) begin
        drain_results();
        cfg_write(directed_rows[i].addr, directed_rows[i].wdata);
      end else begin
        send_pair(directed_rows[i].left, directed_rows[i].right, directed_rows[i].golden,
                  directed_rows[i].gold_left, directed_rows[i].gold_right);
      end
    end

    // Random phases: new settings each phase, bursts of samples at a held level
    // so the envelope climbs into compression and then releases.
    for (int phase = 0; phase < RAND_PHASES; phase++) begin
      drain_results();
      for (int r = 0; r < 6; r++) begin
        case (CFG_ADDR_W'(r))
          REG_THRESHOLD: begin
            case ($urandom_range(0, 4))
              0:       val = '0;
              1:       val = 23'h7FFFFF;
              2:       val = CFG_DATA_W'($urandom_range(0, 8388607));
              default: val = CFG_DATA_W'($urandom_range(0, 3000000));
            endcase
          end
          REG_RATIO: begin
            case ($urandom_range(0, 5))
              0:       val = '0;
              1:       val = CFG_DATA_W'($urandom_range(17, 31));
              2:       val = CFG_DATA_W'($urandom);
              default: val = CFG_DATA_W'($urandom_range(1, 16));
            endcase
          end
          default: begin
            case ($urandom_range(0, 7))
              0:       val = '0;
              1:       val = 23'd32768;
              2:       val = 23'h00FFFF;
              3:       val = CFG_DATA_W'($urandom);
              default: val = CFG_DATA_W'($urandom_range(0, 32768));
            endcase
          end
        endcase
        cfg_write(CFG_ADDR_W'(r), val);
      end
      if ($urandom_range(0, 2) == 0)
        cfg_write($urandom_range(0, 1) ? REG_SPARE_HI : REG_SPARE_LO, CFG_DATA_W'($urandom));

      // First phase runs flat out on both sides; the rest idle at random
      gap_pct   = (phase == 0) ? 0 : $urandom_range(10, 60);
      stall_pct = (phase == 0) ? 0 : $urandom_range(10, 60);
      if (phase == 2) hold_off_req = 1'b1;

      for (int n = 0; n < PHASE_PAIRS; n++) begin
        if (n % BURST_PAIRS == 0) begin
          case ($urandom_range(0, 4))
            0:       amp = 8388607;
            1:       amp = 4000000;
            2:       amp = 1000000;
            3:       amp = 50000;
            default: amp = $urandom_range(1, 8388607);
          endcase
        end
        send_pair(random_sample(amp), random_sample(amp), 1'b0, '0, '0);
      end
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (mismatches == 0)
      $display("** stereo_dynamic_range_compressor: PASSED **");
    else
      $display("** stereo_dynamic_range_compressor: FAILED **");
    $finish;
  end

endmodule
